/* hw/rtl/json_string_unescape_top_defines.svh */
// Assertion macros shared by the JSON string unescaper RTL
`ifndef JSON_STRING_UNESCAPE_TOP_DEFINES_SVH
`define JSON_STRING_UNESCAPE_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// clocked check, masked while reset is asserted
`define JSU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked check that also holds across reset
`define JSU_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define JSU_ASSERT(lbl, prop, msg)
`define JSU_ASSERT_RST(lbl, prop, msg)

`endif

`endif

/* hw/rtl/jsu_pkg.sv */
// Shared types and constants for the JSON string unescaper
`default_nettype none

package jsu_pkg;

    localparam int MAX_CAPACITY = 4096;

    localparam int BYTE_W = 8;
    localparam int CFG_W  = 13;
    localparam int POS_W  = 12;
    localparam int CNT_W  = $clog2(MAX_CAPACITY);
    localparam int CAPE_W = $clog2(MAX_CAPACITY + 1);
    localparam int CMP_W  = (CAPE_W > CFG_W) ? CAPE_W : CFG_W;

    localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(4096);

    localparam int TDATA_W = 24;
    localparam int TUSER_W = 3;

    typedef enum logic [1:0] {
        ST_CONT = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } status_t;

    typedef struct packed {
        logic              store_valid;
        logic [BYTE_W-1:0] out_byte;
        logic [POS_W-1:0]  position;
        status_t           status;
    } jsu_result_t;

endpackage

`default_nettype wire

/* hw/rtl/jsu_core.sv */
// Unescape state machine: string state and per-byte decode
`default_nettype none

`include "json_string_unescape_top_defines.svh"

module jsu_core
    import jsu_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,       // consume in_byte this cycle
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic [CFG_W-1:0]  capacity,
    output jsu_result_t            result
);

    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_B      = 8'h62;
    localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
    localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
    localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
    localparam logic [BYTE_W-1:0] CH_U      = 8'h75;
    localparam logic [BYTE_W-1:0] CH_QMARK  = 8'h3F;
    localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
    localparam logic [BYTE_W-1:0] CH_FF     = 8'h0C;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;

    typedef enum logic [3:0] {
        PH_EXPECT = 4'b0001,
        PH_BODY   = 4'b0010,
        PH_ESCAPE = 4'b0100,
        PH_HEX    = 4'b1000
    } phase_t;

    // bit 4 set marks a non-hex character
    function automatic logic [4:0] nibble_of(input logic [BYTE_W-1:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b0, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b0, 4'(b - 8'h37)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    phase_t             phase_reg, phase_next;
    logic [1:0]         hex_cnt_reg, hex_cnt_next;
    logic [15:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic [CMP_W-1:0]   cap_wide;
    logic [CMP_W-1:0]   cap_eff;
    logic               can_store;
    logic               do_store;
    logic               do_fail;
    logic [BYTE_W-1:0]  ch;
    logic [4:0]         nib;
    logic [15:0]        acc_shift;

    assign cap_wide  = CMP_W'(capacity);
    assign cap_eff   = (cap_wide > CMP_W'(MAX_CAPACITY)) ? CMP_W'(MAX_CAPACITY) : cap_wide;
    assign can_store = (CMP_W'(count_reg) + CMP_W'(1)) < cap_eff;
    assign nib       = nibble_of(in_byte);
    assign acc_shift = {acc_reg[11:0], nib[3:0]};

    always_comb begin
        phase_next   = phase_reg;
        hex_cnt_next = hex_cnt_reg;
        acc_next     = acc_reg;
        count_next   = count_reg;
        do_store     = 1'b0;
        do_fail      = 1'b0;
        ch           = '0;
        result       = '{store_valid: 1'b0, out_byte: '0, position: '0, status: ST_CONT};

        unique case (phase_reg)
            PH_EXPECT: begin
                if (in_byte != CH_QUOTE || capacity == '0) begin
                    do_fail = 1'b1;
                end else begin
                    phase_next = PH_BODY;
                    count_next = '0;
                end
            end
            PH_BODY: begin
                if (in_byte == '0) begin
                    do_fail = 1'b1;
                end else if (in_byte == CH_QUOTE) begin
                    phase_next      = PH_EXPECT;
                    result.status   = ST_DONE;
                    result.position = POS_W'(count_reg);
                end else if (in_byte == CH_BSLASH) begin
                    phase_next = PH_ESCAPE;
                end else begin
                    do_store = 1'b1;
                    ch       = in_byte;
                end
            end
            PH_ESCAPE: begin
                unique case (in_byte) inside
                    CH_QUOTE, CH_BSLASH, CH_SLASH: begin
                        do_store = 1'b1;
                        ch       = in_byte;
                    end
                    CH_B: begin
                        do_store = 1'b1;
                        ch       = CH_BS;
                    end
                    CH_F: begin
                        do_store = 1'b1;
                        ch       = CH_FF;
                    end
                    CH_N: begin
                        do_store = 1'b1;
                        ch       = CH_LF;
                    end
                    CH_R: begin
                        do_store = 1'b1;
                        ch       = CH_CR;
                    end
                    CH_T: begin
                        do_store = 1'b1;
                        ch       = CH_TAB;
                    end
                    CH_U: begin
                        phase_next   = PH_HEX;
                        hex_cnt_next = '0;
                        acc_next     = '0;
                    end
                    default: begin
                        do_fail = 1'b1;
                    end
                endcase
                if (do_store) begin
                    phase_next = PH_BODY;
                end
            end
            PH_HEX: begin
                if (nib[4]) begin
                    do_fail = 1'b1;
                end else begin
                    acc_next = acc_shift;
                    if (hex_cnt_reg == 2'd3) begin
                        hex_cnt_next = '0;
                        phase_next   = PH_BODY;
                        do_store     = 1'b1;
                        // printable ASCII passes through, anything else is '?'
                        ch = (acc_shift >= 16'd32 && acc_shift < 16'd127) ?
                             acc_shift[BYTE_W-1:0] : CH_QMARK;
                    end else begin
                        hex_cnt_next = hex_cnt_reg + 2'd1;
                    end
                end
            end
            default: begin
                do_fail = 1'b1;
            end
        endcase

        if (do_fail) begin
            phase_next    = PH_EXPECT;
            hex_cnt_next  = '0;
            acc_next      = '0;
            result.status = ST_ERR;
        end

        // buffer full: drop the byte, keep parsing
        if (do_store && can_store) begin
            result.store_valid = 1'b1;
            result.out_byte    = ch;
            result.position    = POS_W'(count_reg);
            count_next         = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_EXPECT;
            hex_cnt_reg <= '0;
            acc_reg     <= '0;
            count_reg   <= '0;
        end else if (step) begin
            phase_reg   <= phase_next;
            hex_cnt_reg <= hex_cnt_next;
            acc_reg     <= acc_next;
            count_reg   <= count_next;
        end
    end

    `JSU_ASSERT(a_hex_cnt_idle, phase_reg != PH_HEX |-> hex_cnt_reg == 2'd0, "hex digit count outside hex phase")
    `JSU_ASSERT(a_count_step, step && result.store_valid |=> count_reg == CNT_W'($past(count_reg) + 1'b1), "stored count did not advance on store")
    `JSU_ASSERT_RST(a_reset_phase, !aresetn |=> phase_reg == PH_EXPECT, "phase not at expect-quote after reset")

endmodule

`default_nettype wire

/* hw/rtl/json_string_unescape_top.sv */
// A word accepted on s_ passes through the input register, then the result register, to m_.
// One word per cycle unless m_ stalls; decode is one pass through the string state machine.
// s_tready falls only while a word waits in the input register behind a stalled result.
// Reset (aresetn low, synchronous): pipeline emptied, state waits for an opening quote,
// capacity returns to 4096.
`default_nettype none

`include "json_string_unescape_top_defines.svh"

module json_string_unescape_top
    import jsu_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // configuration: capacity
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_wdata,
    // input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [BYTE_W-1:0]  s_tdata,   // [7:0] in_byte
    // result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [7:0] out_byte, [19:8] position, rest zero
    output logic [TUSER_W-1:0]      m_tuser    // [0] store_valid, [2:1] status
);

    logic [CFG_W-1:0]  capacity_reg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    jsu_result_t       out_res_reg;
    jsu_result_t       core_res;
    logic              advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else if (cfg_we) begin
            capacity_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
    end

    jsu_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .in_byte  (in_byte_reg),
        .capacity (capacity_reg),
        .result   (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - POS_W - BYTE_W)'(0), out_res_reg.position, out_res_reg.out_byte};
    assign m_tuser  = {out_res_reg.status, out_res_reg.store_valid};

    `JSU_ASSERT(a_in_hold, in_valid_reg && !advance |=> in_valid_reg, "input word lost while stalled")
    `JSU_ASSERT(a_store_cont, out_valid_reg && out_res_reg.store_valid |-> out_res_reg.status == ST_CONT, "store flagged on a terminating word")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for json_string_unescape_top: byte stream in, decoded bytes out
`timescale 1ns / 100ps

module testbench;
    import jsu_pkg::*;

    localparam int ITEM_TARGET      = 950;
    localparam int NO_ACCEPT_LIMIT  = 2000;
    localparam int CALM_TAIL        = 150;
    localparam int END_WAIT         = 6;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_LOWER_B = 8'h62;
    localparam logic [7:0] CH_LOWER_F = 8'h66;
    localparam logic [7:0] CH_LOWER_N = 8'h6E;
    localparam logic [7:0] CH_LOWER_R = 8'h72;
    localparam logic [7:0] CH_LOWER_T = 8'h74;
    localparam logic [7:0] CH_LOWER_U = 8'h75;
    localparam logic [7:0] CTL_BS     = 8'h08;
    localparam logic [7:0] CTL_TAB    = 8'h09;
    localparam logic [7:0] CTL_LF     = 8'h0A;
    localparam logic [7:0] CTL_FF     = 8'h0C;
    localparam logic [7:0] CTL_CR     = 8'h0D;
    localparam int         PRINT_LO   = 32;
    localparam int         PRINT_END  = 127;
    localparam logic [4:0] NOT_HEX    = 5'd16;

    typedef enum logic [1:0] {
        AWAIT_QUOTE,
        IN_BODY,
        IN_ESCAPE,
        IN_HEX
    } parse_phase_e;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic [BYTE_W-1:0]    s_tdata   = '0;
    logic                 m_tready  = 1'b0;
    wire                  s_tready;
    wire                  m_tvalid;
    wire  [TDATA_W-1:0]   m_tdata;
    wire  [TUSER_W-1:0]   m_tuser;

    json_string_unescape_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // decoder state mirrored in the testbench
    parse_phase_e     ph        = AWAIT_QUOTE;
    logic [1:0]       hex_seen  = '0;
    logic [15:0]      code_acc  = '0;
    logic [12:0]      n_stored  = '0;
    logic [CFG_W-1:0] cap_reg   = CAP_RESET;

    jsu_result_t pending_decodes[$];
    int          errors      = 0;
    int          items_sent  = 0;
    int          words_seen  = 0;
    bit          stall_on    = 1'b1;

    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39) return 5'(b - 8'h30);
        if (b >= 8'h61 && b <= 8'h66) return 5'(b - 8'h61 + 10);
        if (b >= 8'h41 && b <= 8'h46) return 5'(b - 8'h41 + 10);
        return NOT_HEX;
    endfunction

    function automatic jsu_result_t parse_error();
        jsu_result_t r;
        r          = '0;
        r.status   = ST_ERR;
        ph         = AWAIT_QUOTE;
        hex_seen   = '0;
        code_acc   = '0;
        return r;
    endfunction

    function automatic jsu_result_t put_byte(input logic [7:0] c);
        jsu_result_t r;
        int          cap;
        cap      = (cap_reg > MAX_CAPACITY) ? MAX_CAPACITY : int'(cap_reg);
        r        = '0;
        r.status = ST_CONT;
        // one slot is kept back for the terminator, so capacity-1 bytes at most
        if (int'(n_stored) + 1 < cap) begin
            r.store_valid = 1'b1;
            r.out_byte    = c;
            r.position    = n_stored[POS_W-1:0];
            n_stored      = n_stored + 1'b1;
        end
        return r;
    endfunction

    function automatic jsu_result_t decode_step(input logic [7:0] b);
        jsu_result_t r;
        logic [4:0]  nib;
        r        = '0;
        r.status = ST_CONT;
        case (ph)
            AWAIT_QUOTE: begin
                if (b != CH_QUOTE || cap_reg == 0) begin
                    r = parse_error();
                end else begin
                    ph       = IN_BODY;
                    n_stored = '0;
                end
            end
            IN_BODY: begin
                if (b == 8'h00) begin
                    r = parse_error();
                end else if (b == CH_QUOTE) begin
                    ph         = AWAIT_QUOTE;
                    r.position = n_stored[POS_W-1:0];
                    r.status   = ST_DONE;
                end else if (b == CH_BSLASH) begin
                    ph = IN_ESCAPE;
                end else begin
                    r = put_byte(b);
                end
            end
            IN_ESCAPE: begin
                ph = IN_BODY;
                case (b)
                    CH_QUOTE, CH_BSLASH, CH_SLASH: r = put_byte(b);
                    CH_LOWER_B: r = put_byte(CTL_BS);
                    CH_LOWER_F: r = put_byte(CTL_FF);
                    CH_LOWER_N: r = put_byte(CTL_LF);
                    CH_LOWER_R: r = put_byte(CTL_CR);
                    CH_LOWER_T: r = put_byte(CTL_TAB);
                    CH_LOWER_U: begin
                        ph       = IN_HEX;
                        hex_seen = '0;
                        code_acc = '0;
                    end
                    default: r = parse_error();
                endcase
            end
            default: begin
                nib = hex_nibble(b);
                if (nib == NOT_HEX) begin
                    r = parse_error();
                end else begin
                    code_acc = {code_acc[11:0], nib[3:0]};
                    if (hex_seen == 2'd3) begin
                        hex_seen = '0;
                        ph       = IN_BODY;
                        if (code_acc >= PRINT_LO && code_acc < PRINT_END)
                            r = put_byte(code_acc[7:0]);
                        else
                            r = put_byte(CH_QMARK);
                    end else begin
                        hex_seen = hex_seen + 1'b1;
                    end
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on word %0d: %s got %0d, want %0d", words_seen, what, got, want);
        errors++;
    endtask

    // all driving tasks are entered just after a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (stall_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        pending_decodes.push_back(decode_step(b));
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_text(input string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_decodes.size() != 0);
    endtask

    task automatic write_capacity(input logic [CFG_W-1:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cap_reg    = value;
    endtask

    // receiver side: random stall bursts on m_tready
    int ready_hold = 0;
    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_tready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 4) == 0) begin
            ready_hold = $urandom_range(0, 2);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin : check_results
        jsu_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            words_seen++;
            if (pending_decodes.size() == 0) begin
                report_mismatch("unexpected word, tdata", int'(m_tdata), 0);
            end else begin
                want = pending_decodes.pop_front();
                if (m_tuser[0] !== want.store_valid)
                    report_mismatch("store_valid", int'(m_tuser[0]), int'(want.store_valid));
                if (m_tdata[7:0] !== want.out_byte)
                    report_mismatch("out_byte", int'(m_tdata[7:0]), int'(want.out_byte));
                if (m_tdata[19:8] !== want.position)
                    report_mismatch("position", int'(m_tdata[19:8]), int'(want.position));
                if (m_tuser[2:1] !== want.status)
                    report_mismatch("status", int'(m_tuser[2:1]), int'(want.status));
                if (m_tdata[TDATA_W-1:20] !== '0)
                    report_mismatch("tdata padding", int'(m_tdata[TDATA_W-1:20]), 0);
            end
        end
    end

    int no_accept = 0;
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            no_accept = 0;
        else
            no_accept++;
        if (no_accept >= NO_ACCEPT_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 10) return 8'h30 + 8'(n);
        return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] escape_letter(input int k);
        case (k)
            0:       return CH_QUOTE;
            1:       return CH_BSLASH;
            2:       return CH_SLASH;
            3:       return CH_LOWER_B;
            4:       return CH_LOWER_F;
            5:       return CH_LOWER_N;
            6:       return CH_LOWER_R;
            default: return CH_LOWER_T;
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_capacity(input int k);
        case (k % 8)
            0:       return '0;
            1:       return CFG_W'(1);
            2:       return CFG_W'(2);
            3:       return CFG_W'($urandom_range(3, 8));
            4:       return CFG_W'(MAX_CAPACITY);
            5:       return '1;
            6:       return CFG_W'($urandom_range(0, 8191));
            default: return CFG_W'($urandom_range(4, 20));
        endcase
    endfunction

    task automatic send_random_string(input bit broken);
        logic [7:0] seq[$];
        logic [7:0] c;
        logic [15:0] code;
        int n_elem, kind, at;
        n_elem = $urandom_range(0, 12);
        seq.push_back(CH_QUOTE);
        repeat (n_elem) begin
            kind = $urandom_range(0, 9);
            if (kind <= 4) begin
                do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
                seq.push_back(c);
            end else if (kind <= 6) begin
                seq.push_back(CH_BSLASH);
                seq.push_back(escape_letter($urandom_range(0, 7)));
            end else begin
                case (kind)
                    7:       code = 16'($urandom_range(PRINT_LO, PRINT_END - 1));
                    8:       code = 16'($urandom_range(0, 65535));
                    default: begin
                        case ($urandom_range(0, 3))
                            0:       code = 16'(PRINT_LO - 1);
                            1:       code = 16'(PRINT_LO);
                            2:       code = 16'(PRINT_END - 1);
                            default: code = 16'(PRINT_END);
                        endcase
                    end
                endcase
                seq.push_back(CH_BSLASH);
                seq.push_back(CH_LOWER_U);
                for (int d = 3; d >= 0; d--)
                    seq.push_back(hex_char(code[d*4 +: 4], bit'($urandom_range(0, 1))));
            end
        end
        seq.push_back(CH_QUOTE);
        if (broken) begin
            at = $urandom_range(1, seq.size() - 1);
            if ($urandom_range(0, 3) == 0)
                seq = seq[0:at-1];      // cut short, closing quote lost
            else
                seq.insert(at, 8'($urandom_range(0, 255)));
        end
        foreach (seq[i]) send_byte(seq[i]);
    endtask

    task automatic test_default_capacity();
        send_text("\"ab\"");
    endtask

    task automatic test_escapes();
        send_text("\"\\t\\u004a\\uFFFf\\/\"");
    endtask

    task automatic test_error_paths();
        send_byte(8'hFF);               // no opening quote
        send_text("\"\\q");             // unknown escape
        send_text("\"\\u0G");           // non-hex digit
        send_text("\"");
        send_byte(8'hFF);
        send_byte(8'h00);               // end of input inside the body
    endtask

    task automatic test_capacity();
        write_capacity('0);
        send_byte(CH_QUOTE);            // refused at the opening quote
        write_capacity(CFG_W'(1));
        send_text("\"ab\"");
        write_capacity(CFG_W'(2));
        send_text("\"ab\"");
        write_capacity(CFG_W'(3));
        send_text("\"a\\n");
        // change in the middle of a string, above the maximum
        write_capacity('1);
        send_text("b\"");
        write_capacity(CFG_W'(MAX_CAPACITY));
    endtask

    task automatic test_random_strings();
        int phase_no;
        int r;
        phase_no = 0;
        while (items_sent < ITEM_TARGET) begin
            write_capacity(pick_capacity(phase_no));
            for (int s = 0; s < 4; s++) begin
                stall_on = (items_sent < ITEM_TARGET - CALM_TAIL);
                r = $urandom_range(0, 9);
                if (r == 0)
                    send_byte(8'($urandom_range(0, 255)));
                else
                    send_random_string(r == 1);
                if (phase_no == 2 && s == 1)
                    drain_results();    // sender holds off until the output is empty
            end
            phase_no++;
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_default_capacity();
        test_escapes();
        test_error_paths();
        test_capacity();
        test_random_strings();
        drain_results();
        repeat (END_WAIT) @(negedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
